// File: rtl/core/it_sdd_pkg.sv
`default_nettype none
package it_sdd_pkg;

   localparam logic [1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [1:0] KIND_FINISHED = 2'd1;
   localparam logic [1:0] KIND_OVERRUN  = 2'd2;
   localparam logic [1:0] KIND_BADWIDTH = 2'd3;

   localparam logic [2:0] REG_SIXTEEN_BIT      = 3'd0;
   localparam logic [2:0] REG_DOUBLE_INTEGRATE = 3'd1;
   localparam logic [2:0] REG_SAMPLE_COUNT     = 3'd2;
   localparam logic [2:0] REG_CHANNEL_STRIDE   = 3'd3;
   localparam logic [2:0] REG_INPUT_LENGTH     = 3'd4;

   localparam logic [1:0] PH_LOW  = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_STOP = 2'd3;

   localparam logic [7:0] WIDTH8_START  = 8'd9;
   localparam logic [7:0] WIDTH16_START = 8'd17;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
      logic [34:0] offset;
      logic [31:0] bytes;
   } result_type;

   typedef struct packed {
      logic load;
      logic commit;
      logic cfg_we;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic done;
   } dp_stat_type;

   typedef struct packed {
      logic push;
      logic flush;
   } oq_cmd_type;

   typedef struct packed {
      logic pend_valid;
      logic out_free;
   } oq_stat_type;

endpackage
`default_nettype wire

// File: rtl/core/it_sdd_ctrl.sv
`default_nettype none
module it_sdd_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire it_sdd_pkg::dp_stat_type  dp_stat,
   output it_sdd_pkg::dp_cmd_type        dp_cmd,
   input  wire it_sdd_pkg::oq_stat_type  oq_stat,
   output it_sdd_pkg::oq_cmd_type        oq_cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       can_step;

   assign req_stall = (state_ff != ST_IDLE);
   // an offered item goes first
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;

   // a new result needs room to move the held one out
   assign can_step = !dp_stat.emit || !oq_stat.pend_valid || oq_stat.out_free;

   always_comb begin
      state_in      = state_ff;
      dp_cmd.load   = 1'b0;
      dp_cmd.commit = 1'b0;
      dp_cmd.cfg_we = csr_valid && csr_ready;
      oq_cmd.push   = 1'b0;
      oq_cmd.flush  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (can_step) begin
               dp_cmd.commit = 1'b1;
               oq_cmd.push   = dp_stat.emit;
               if (dp_stat.done) state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!oq_stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (oq_stat.out_free) begin
               oq_cmd.flush = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_load_runs: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |=> state_ff == ST_RUN)
      else $error("load did not start a run");
   a_push_in_run: assert property (@(posedge clock) disable iff (reset)
      oq_cmd.push |-> (state_ff == ST_RUN && dp_cmd.commit))
      else $error("result pushed outside a step");

endmodule
`default_nettype wire

// File: rtl/core/it_sdd_dpath.sv
`default_nettype none
module it_sdd_dpath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [7:0]              req_input_byte,
   input  wire logic [2:0]              csr_index,
   input  wire logic [31:0]             csr_wdata,
   input  wire it_sdd_pkg::dp_cmd_type  dp_cmd,
   output it_sdd_pkg::dp_stat_type      dp_stat,
   output it_sdd_pkg::result_type       result
);

   localparam logic [7:0] WIDTH8  = it_sdd_pkg::WIDTH8_START;
   localparam logic [7:0] WIDTH16 = it_sdd_pkg::WIDTH16_START;

   // configuration
   logic        sixteen_ff, sixteen_in;
   logic        dbl_ff, dbl_in;
   logic [3:0]  stride_ff, stride_in;
   logic [31:0] inlen_ff, inlen_in;
   // decoder state
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  phase_ff, phase_in, nx_phase;
   logic        fin_ff, fin_in, nx_fin;
   logic [7:0]  hdr_ff, hdr_in, nx_hdr;
   logic [31:0] bitbuf_ff, bitbuf_in, nx_bitbuf;
   logic [5:0]  bitcnt_ff, bitcnt_in, nx_bitcnt;
   logic [7:0]  cw_ff, cw_in, nx_cw;
   logic        esc_ff, esc_in, nx_esc;
   logic [15:0] int1_ff, int1_in, nx_int1;
   logic [15:0] int2_ff, int2_in, nx_int2;
   logic [15:0] blk_ff, blk_in, nx_blk;
   logic [31:0] tot_ff, tot_in, nx_tot;
   logic [31:0] bcnt_ff, bcnt_in, nx_bcnt;
   logic [34:0] off_ff, off_in, nx_off;

   // step terms
   logic [7:0]  maxw, start_w;
   logic        illegal, enough, top_bit, in_win;
   logic [4:0]  need, nv, dlt, sw, sb;
   logic [16:0] mask17, val, esc_code;
   logic [17:0] val18, border, span;
   logic [7:0]  bord8;
   logic [15:0] bord16, cap, wm16, v16, smask, s1, s2, o;
   logic [31:0] bc1;
   logic [32:0] blk_end;
   logic [15:0] blk_dec;
   logic [31:0] tot_dec;

   always_comb begin
      maxw     = sixteen_ff ? WIDTH16 : WIDTH8;
      start_w  = maxw;
      illegal  = (cw_ff == 8'd0) || (cw_ff > maxw);
      need     = esc_ff ? (sixteen_ff ? 5'd4 : 5'd3) : cw_ff[4:0];
      enough   = ({1'b0, need} <= bitcnt_ff);
      mask17   = 17'((18'h1 << need) - 18'h1);
      val      = bitbuf_ff[16:0] & mask17;
      val18    = {1'b0, val};
      nv       = 5'({1'b0, val[3:0]} + 5'd1);
      esc_code = 17'h1 << (cw_ff[4:0] - 5'd1);
      bord8    = 8'((8'hFF >> (4'd9 - cw_ff[3:0])) - 8'd4);
      bord16   = 16'((16'hFFFF >> (5'd17 - cw_ff[4:0])) - 16'd8);
      border   = sixteen_ff ? {2'b00, bord16} : {10'd0, bord8};
      span     = sixteen_ff ? 18'd16 : 18'd8;
      in_win   = (val18 > border) && (val18 <= border + span);
      dlt      = 5'(val18 - border);
      top_bit  = sixteen_ff ? val[16] : val[8];
      sb       = sixteen_ff ? 5'd16 : 5'd8;
      sw       = ({3'b000, sb} > cw_ff) ? cw_ff[4:0] : sb;
      wm16     = 16'((17'h1 << sw) - 17'h1);
      v16      = val[15:0] & wm16;
      if (v16[4'(sw - 5'd1)]) v16 = v16 | ~wm16;
      smask    = sixteen_ff ? 16'hFFFF : 16'h00FF;
      s1       = (int1_ff + v16) & smask;
      s2       = (int2_ff + s1) & smask;
      o        = dbl_ff ? s2 : s1;
      if (!sixteen_ff) o = {{8{o[7]}}, o[7:0]};
      cap      = sixteen_ff ? 16'h4000 : 16'h8000;
      bc1      = bcnt_ff + 32'd1;
      blk_end  = {1'b0, bc1} + {17'd0, byte_ff, hdr_ff};
      blk_dec  = (blk_ff != 16'd0) ? blk_ff - 16'd1 : blk_ff;
      tot_dec  = (tot_ff != 32'd0) ? tot_ff - 32'd1 : tot_ff;
   end

   // one loop pass of the decoder
   always_comb begin
      nx_phase  = phase_ff;
      nx_fin    = fin_ff;
      nx_hdr    = hdr_ff;
      nx_bitbuf = bitbuf_ff;
      nx_bitcnt = bitcnt_ff;
      nx_cw     = cw_ff;
      nx_esc    = esc_ff;
      nx_int1   = int1_ff;
      nx_int2   = int2_ff;
      nx_blk    = blk_ff;
      nx_tot    = tot_ff;
      nx_bcnt   = bcnt_ff;
      nx_off    = off_ff;
      dp_stat.emit  = 1'b0;
      dp_stat.done  = 1'b0;
      result.kind   = it_sdd_pkg::KIND_SAMPLE;
      result.value  = 16'd0;
      result.offset = 35'd0;
      result.bytes  = 32'd0;
      if (fin_ff) begin
         nx_fin        = 1'b0;
         dp_stat.emit  = 1'b1;
         dp_stat.done  = 1'b1;
         result.kind   = it_sdd_pkg::KIND_FINISHED;
         result.bytes  = bcnt_ff;
      end else begin
         unique case (phase_ff)
            it_sdd_pkg::PH_LOW: begin
               dp_stat.done = 1'b1;
               if (tot_ff == 32'd0) begin
                  dp_stat.emit = 1'b1;
                  result.kind  = it_sdd_pkg::KIND_FINISHED;
                  result.bytes = bcnt_ff;
                  nx_phase     = it_sdd_pkg::PH_STOP;
               end else begin
                  nx_hdr   = byte_ff;
                  nx_bcnt  = bc1;
                  nx_phase = it_sdd_pkg::PH_HIGH;
               end
            end
            it_sdd_pkg::PH_HIGH: begin
               dp_stat.done = 1'b1;
               nx_bcnt      = bc1;
               if (blk_end > {1'b0, inlen_ff}) begin
                  dp_stat.emit = 1'b1;
                  result.kind  = it_sdd_pkg::KIND_OVERRUN;
                  result.bytes = bc1;
                  nx_phase     = it_sdd_pkg::PH_STOP;
               end else begin
                  nx_bitbuf = 32'd0;
                  nx_bitcnt = 6'd0;
                  nx_esc    = 1'b0;
                  nx_int1   = 16'd0;
                  nx_int2   = 16'd0;
                  nx_cw     = start_w;
                  nx_blk    = (tot_ff < {16'd0, cap}) ? tot_ff[15:0] : cap;
                  nx_phase  = it_sdd_pkg::PH_DATA;
               end
            end
            it_sdd_pkg::PH_DATA: begin
               if (illegal) begin
                  dp_stat.emit = 1'b1;
                  dp_stat.done = 1'b1;
                  result.kind  = it_sdd_pkg::KIND_BADWIDTH;
                  result.bytes = bcnt_ff;
                  nx_phase     = it_sdd_pkg::PH_STOP;
               end else if (!enough) begin
                  dp_stat.done = 1'b1;
               end else begin
                  nx_bitbuf = bitbuf_ff >> need;
                  nx_bitcnt = bitcnt_ff - {1'b0, need};
                  if (esc_ff) begin
                     nx_esc = 1'b0;
                     nx_cw  = ({3'b000, nv} < cw_ff) ? {3'b000, nv} : {3'b000, nv} + 8'd1;
                  end else if (cw_ff < 8'd7 && val == esc_code) begin
                     nx_esc = 1'b1;
                  end else if (cw_ff >= 8'd7 && cw_ff < maxw && in_win) begin
                     nx_cw = ({3'b000, dlt} < cw_ff) ? {3'b000, dlt} : {3'b000, dlt} + 8'd1;
                  end else if (cw_ff == maxw && top_bit) begin
                     nx_cw = val[7:0] + 8'd1;
                  end else begin
                     nx_int1       = s1;
                     nx_int2       = s2;
                     dp_stat.emit  = 1'b1;
                     result.kind   = it_sdd_pkg::KIND_SAMPLE;
                     result.value  = o;
                     result.offset = off_ff;
                     nx_off        = off_ff + {31'd0, stride_ff};
                     nx_blk        = blk_dec;
                     nx_tot        = tot_dec;
                     if (blk_dec == 16'd0) begin
                        // drop the rest of the byte
                        if (tot_dec == 32'd0) begin
                           nx_fin   = 1'b1;
                           nx_phase = it_sdd_pkg::PH_STOP;
                        end else begin
                           nx_phase     = it_sdd_pkg::PH_LOW;
                           dp_stat.done = 1'b1;
                        end
                     end
                  end
               end
            end
            it_sdd_pkg::PH_STOP: dp_stat.done = 1'b1;
            default: dp_stat.done = 1'b1;
         endcase
      end
   end

   always_comb begin
      sixteen_in = sixteen_ff;
      dbl_in     = dbl_ff;
      stride_in  = stride_ff;
      inlen_in   = inlen_ff;
      byte_in    = byte_ff;
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      hdr_in     = hdr_ff;
      bitbuf_in  = bitbuf_ff;
      bitcnt_in  = bitcnt_ff;
      cw_in      = cw_ff;
      esc_in     = esc_ff;
      int1_in    = int1_ff;
      int2_in    = int2_ff;
      blk_in     = blk_ff;
      tot_in     = tot_ff;
      bcnt_in    = bcnt_ff;
      off_in     = off_ff;
      if (dp_cmd.cfg_we) begin
         unique case (csr_index)
            it_sdd_pkg::REG_SIXTEEN_BIT:      sixteen_in = csr_wdata[0];
            it_sdd_pkg::REG_DOUBLE_INTEGRATE: dbl_in     = csr_wdata[0];
            it_sdd_pkg::REG_CHANNEL_STRIDE:   stride_in  = csr_wdata[3:0];
            it_sdd_pkg::REG_INPUT_LENGTH:     inlen_in   = csr_wdata;
            it_sdd_pkg::REG_SAMPLE_COUNT: begin
               tot_in    = csr_wdata;
               phase_in  = it_sdd_pkg::PH_LOW;
               fin_in    = 1'b0;
               bcnt_in   = 32'd0;
               off_in    = 35'd0;
               blk_in    = 16'd0;
               bitbuf_in = 32'd0;
               bitcnt_in = 6'd0;
               esc_in    = 1'b0;
               int1_in   = 16'd0;
               int2_in   = 16'd0;
               cw_in     = start_w;
            end
            default: ;
         endcase
      end else if (dp_cmd.load) begin
         byte_in = req_input_byte;
         if (phase_ff == it_sdd_pkg::PH_DATA) begin
            bitbuf_in = bitbuf_ff | ({24'd0, req_input_byte} << bitcnt_ff);
            bitcnt_in = bitcnt_ff + 6'd8;
            bcnt_in   = bc1;
         end
      end else if (dp_cmd.commit) begin
         phase_in  = nx_phase;
         fin_in    = nx_fin;
         hdr_in    = nx_hdr;
         bitbuf_in = nx_bitbuf;
         bitcnt_in = nx_bitcnt;
         cw_in     = nx_cw;
         esc_in    = nx_esc;
         int1_in   = nx_int1;
         int2_in   = nx_int2;
         blk_in    = nx_blk;
         tot_in    = nx_tot;
         bcnt_in   = nx_bcnt;
         off_in    = nx_off;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         sixteen_ff <= 1'b0;
         dbl_ff     <= 1'b0;
         stride_ff  <= 4'd1;
         inlen_ff   <= 32'd0;
         phase_ff   <= it_sdd_pkg::PH_LOW;
         fin_ff     <= 1'b0;
         hdr_ff     <= 8'd0;
         bitbuf_ff  <= 32'd0;
         bitcnt_ff  <= 6'd0;
         cw_ff      <= WIDTH8;
         esc_ff     <= 1'b0;
         int1_ff    <= 16'd0;
         int2_ff    <= 16'd0;
         blk_ff     <= 16'd0;
         tot_ff     <= 32'd0;
         bcnt_ff    <= 32'd0;
         off_ff     <= 35'd0;
      end else begin
         sixteen_ff <= sixteen_in;
         dbl_ff     <= dbl_in;
         stride_ff  <= stride_in;
         inlen_ff   <= inlen_in;
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         hdr_ff     <= hdr_in;
         bitbuf_ff  <= bitbuf_in;
         bitcnt_ff  <= bitcnt_in;
         cw_ff      <= cw_in;
         esc_ff     <= esc_in;
         int1_ff    <= int1_in;
         int2_ff    <= int2_in;
         blk_ff     <= blk_in;
         tot_ff     <= tot_in;
         bcnt_ff    <= bcnt_in;
         off_ff     <= off_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/it_sdd_outq.sv
`default_nettype none
module it_sdd_outq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire it_sdd_pkg::oq_cmd_type  oq_cmd,
   input  wire it_sdd_pkg::result_type  result,
   output it_sdd_pkg::oq_stat_type      oq_stat,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_result_kind,
   output logic signed [15:0]           rsp_sample_value,
   output logic [34:0]                  rsp_dest_offset,
   output logic [31:0]                  rsp_bytes_consumed,
   output logic                         rsp_last
);

   logic                   pend_valid_ff, pend_valid_in;
   it_sdd_pkg::result_type pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   it_sdd_pkg::result_type out_ff, out_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_free;

   assign out_free           = !out_valid_ff || !rsp_stall;
   assign oq_stat.pend_valid = pend_valid_ff;
   assign oq_stat.out_free   = out_free;

   // hold the newest result until the byte shows whether it is the last one
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (oq_cmd.push) begin
         pend_valid_in = 1'b1;
         pend_in       = result;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_last_in  = 1'b0;
         end
      end else if (oq_cmd.flush) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_ff.kind;
   assign rsp_sample_value   = out_ff.value;
   assign rsp_dest_offset    = out_ff.offset;
   assign rsp_bytes_consumed = out_ff.bytes;
   assign rsp_last           = out_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (oq_cmd.push && pend_valid_ff) |-> out_free)
      else $error("held item pushed into a busy output");
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      oq_cmd.flush |=> (!pend_valid_ff && rsp_valid && rsp_last))
      else $error("flush did not move the held item out");

endmodule
`default_nettype wire

// File: rtl/core/it_sample_delta_decompress.sv
`default_nettype none
// Channel  Direction  Handshake          Payload
// req_     in         valid / stall      input_byte
// rsp_     out        valid / stall      result_kind, sample_value, dest_offset,
//                                        bytes_consumed, last
// csr_     in         valid / ready      index, wdata
//
// One byte at a time: the byte is taken, each code or header step is committed,
// then the last result is released; the code loop sets how many steps a byte needs.
// Synchronous active-high reset; the decoder then awaits a header byte.
// An output stall holds the decoder only when a new result has nowhere to go.
module it_sample_delta_decompress (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_input_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_result_kind,
   output logic signed [15:0]      rsp_sample_value,
   output logic [34:0]             rsp_dest_offset,
   output logic [31:0]             rsp_bytes_consumed,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   it_sdd_pkg::dp_cmd_type  dp_cmd;
   it_sdd_pkg::dp_stat_type dp_stat;
   it_sdd_pkg::oq_cmd_type  oq_cmd;
   it_sdd_pkg::oq_stat_type oq_stat;
   it_sdd_pkg::result_type  result;

   it_sdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd),
      .oq_stat   (oq_stat),
      .oq_cmd    (oq_cmd)
   );

   it_sdd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_input_byte (req_input_byte),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .dp_cmd         (dp_cmd),
      .dp_stat        (dp_stat),
      .result         (result)
   );

   it_sdd_outq u_outq (
      .clock              (clock),
      .reset              (reset),
      .oq_cmd             (oq_cmd),
      .result             (result),
      .oq_stat            (oq_stat),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_dest_offset    (rsp_dest_offset),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

// File: tb/it_sample_delta_decompress_tb.sv
`default_nettype none
module it_sample_delta_decompress_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      it_sdd_pkg::result_type r;
      logic                   last;
   } decoded_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_input_byte = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_result_kind;
   logic signed [15:0] rsp_sample_value;
   logic [34:0] rsp_dest_offset;
   logic [31:0] rsp_bytes_consumed;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = 3'd0;
   logic [31:0] csr_wdata = 32'd0;

   it_sample_delta_decompress dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_input_byte(req_input_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_sample_value(rsp_sample_value),
      .rsp_dest_offset(rsp_dest_offset), .rsp_bytes_consumed(rsp_bytes_consumed),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // decoder shadow: configuration and state
   bit        m_wide, m_dbl;
   bit [31:0] m_count, m_avail;
   bit [3:0]  m_stride = 4'd1;
   bit [31:0] sh_bits, sh_nbits, cw, blk_left, tot_left, byte_cnt;
   bit        esc_pend;
   bit [31:0] integ1, integ2;
   bit [1:0]  dec_phase = it_sdd_pkg::PH_LOW;
   bit [7:0]  hdr_lo;
   bit [34:0] off_cnt;

   decoded_result_type expected_q[$];
   logic [7:0] pend_q[$];
   logic [7:0] stream_q[$];

   int errors = 0;
   int items_sent = 0;
   int samples_seen = 0;
   int status_seen = 0;
   int cycles = 0;
   int hold_kick = 0;
   int hold_seen = 0;
   int hold_cnt = 0;

   task automatic report(input string what);
      errors++;
      if (errors <= 20)
         $display("mismatch @%0t: %s", $time, what);
   endtask

   function automatic void clear_bits();
      sh_bits = 0;
      sh_nbits = 0;
      esc_pend = 0;
      integ1 = 0;
      integ2 = 0;
      cw = m_wide ? 32'd17 : 32'd9;
   endfunction

   function automatic void add_result(input logic [1:0] k, input logic [15:0] v,
                                      input logic [34:0] off, input logic [31:0] nb);
      decoded_result_type e;
      e.r.kind = k;
      e.r.value = v;
      e.r.offset = off;
      e.r.bytes = nb;
      e.last = 1'b0;
      expected_q.push_back(e);
   endfunction

   task automatic apply_reg(input logic [2:0] idx, input logic [31:0] d);
      case (idx)
         it_sdd_pkg::REG_SIXTEEN_BIT: m_wide = d[0];
         it_sdd_pkg::REG_DOUBLE_INTEGRATE: m_dbl = d[0];
         it_sdd_pkg::REG_SAMPLE_COUNT: begin
            m_count = d;
            tot_left = d;
            dec_phase = it_sdd_pkg::PH_LOW;
            byte_cnt = 0;
            off_cnt = 0;
            blk_left = 0;
            clear_bits();
         end
         it_sdd_pkg::REG_CHANNEL_STRIDE: m_stride = d[3:0];
         it_sdd_pkg::REG_INPUT_LENGTH: m_avail = d;
         default: ;
      endcase
   endtask

   task automatic decode_byte(input logic [7:0] b);
      int first_idx;
      bit [31:0] maxw, need, val, blen, cap, nv, border, span, d, sb, smask, sw, wm, v, o;
      bit done, ctl;
      decoded_result_type e;
      first_idx = expected_q.size();
      case (dec_phase)
         it_sdd_pkg::PH_LOW: begin
            if (tot_left == 0) begin
               add_result(it_sdd_pkg::KIND_FINISHED, 16'd0, 35'd0, byte_cnt);
               dec_phase = it_sdd_pkg::PH_STOP;
            end else begin
               hdr_lo = b;
               byte_cnt++;
               dec_phase = it_sdd_pkg::PH_HIGH;
            end
         end
         it_sdd_pkg::PH_HIGH: begin
            blen = {16'd0, b, hdr_lo};
            cap = m_wide ? 32'h4000 : 32'h8000;
            byte_cnt++;
            if ({32'd0, byte_cnt} + {32'd0, blen} > {32'd0, m_avail}) begin
               add_result(it_sdd_pkg::KIND_OVERRUN, 16'd0, 35'd0, byte_cnt);
               dec_phase = it_sdd_pkg::PH_STOP;
            end else begin
               clear_bits();
               blk_left = tot_left < cap ? tot_left : cap;
               dec_phase = it_sdd_pkg::PH_DATA;
            end
         end
         it_sdd_pkg::PH_DATA: begin
            byte_cnt++;
            sh_bits |= {24'd0, b} << sh_nbits;
            sh_nbits += 8;
            done = 0;
            while (!done) begin
               maxw = m_wide ? 32'd17 : 32'd9;
               if (cw == 0 || cw > maxw) begin
                  add_result(it_sdd_pkg::KIND_BADWIDTH, 16'd0, 35'd0, byte_cnt);
                  dec_phase = it_sdd_pkg::PH_STOP;
                  done = 1;
               end else begin
                  need = esc_pend ? (m_wide ? 32'd4 : 32'd3) : cw;
                  if (sh_nbits < need) begin
                     done = 1;
                  end else begin
                     val = sh_bits & ((32'd1 << need) - 1);
                     sh_bits >>= need;
                     sh_nbits -= need;
                     ctl = 1;
                     if (esc_pend) begin
                        nv = val + 1;
                        esc_pend = 0;
                        cw = nv < cw ? nv : nv + 1;
                     end else if (cw < 7) begin
                        if (val == (32'd1 << (cw - 1))) esc_pend = 1;
                        else ctl = 0;
                     end else if (cw < maxw) begin
                        if (m_wide) begin
                           border = (32'hFFFF >> (17 - cw)) - 8;
                           span = 16;
                        end else begin
                           border = ((32'hFF >> (9 - cw)) - 4) & 32'hFF;
                           span = 8;
                        end
                        if (val > border && val <= border + span) begin
                           d = val - border;
                           cw = d < cw ? d : d + 1;
                        end else begin
                           ctl = 0;
                        end
                     end else if (val[maxw - 1]) begin
                        cw = (val + 1) & 32'hFF;
                     end else begin
                        ctl = 0;
                     end
                     if (!ctl) begin
                        sb = m_wide ? 32'd16 : 32'd8;
                        smask = m_wide ? 32'hFFFF : 32'hFF;
                        sw = cw < sb ? cw : sb;
                        wm = (32'd1 << sw) - 1;
                        v = val & wm;
                        if (v[sw - 1]) v |= ~wm;
                        integ1 = (integ1 + v) & smask;
                        integ2 = (integ2 + integ1) & smask;
                        o = m_dbl ? integ2 : integ1;
                        if (!m_wide && o[7]) o |= 32'hFF00;
                        add_result(it_sdd_pkg::KIND_SAMPLE, o[15:0], off_cnt, 32'd0);
                        off_cnt = off_cnt + {31'd0, m_stride};
                        if (blk_left > 0) blk_left--;
                        if (tot_left > 0) tot_left--;
                        if (blk_left == 0) begin
                           if (tot_left == 0) begin
                              add_result(it_sdd_pkg::KIND_FINISHED, 16'd0, 35'd0, byte_cnt);
                              dec_phase = it_sdd_pkg::PH_STOP;
                           end else begin
                              dec_phase = it_sdd_pkg::PH_LOW;
                           end
                           done = 1;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (expected_q.size() > first_idx) begin
         e = expected_q.pop_back();
         e.last = 1'b1;
         expected_q.push_back(e);
      end
   endtask

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         decode_byte(req_input_byte);
         items_sent++;
      end
      if (!req_valid || !req_stall) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (burst_left > 0 && pend_q.size() > 0) begin
            req_valid <= 1'b1;
            req_input_byte <= pend_q.pop_front();
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            if (burst_left == 0 && gap_left > 0) gap_left--;
         end
      end
   end

   // long hold-off on the result side
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_cnt <= HOLD_CYCLES;
      end
   end

   // receiver: check results, stall on a changing pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      decoded_result_type e;
      if (rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result kind %0d", rsp_result_kind));
         end else begin
            e = expected_q.pop_front();
            if (rsp_result_kind == it_sdd_pkg::KIND_SAMPLE) samples_seen++;
            else status_seen++;
            if (rsp_result_kind !== e.r.kind)
               report($sformatf("kind %0d, want %0d", rsp_result_kind, e.r.kind));
            if (rsp_sample_value !== e.r.value)
               report($sformatf("value %h, want %h", rsp_sample_value, e.r.value));
            if (rsp_dest_offset !== e.r.offset)
               report($sformatf("offset %0d, want %0d", rsp_dest_offset, e.r.offset));
            if (rsp_bytes_consumed !== e.r.bytes)
               report($sformatf("bytes %0d, want %0d", rsp_bytes_consumed, e.r.bytes));
            if (rsp_last !== e.last)
               report($sformatf("last %b, want %b", rsp_last, e.last));
         end
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= (hold_cnt > 1);
         1: rsp_stall <= (hold_cnt > 1) || ($urandom_range(0, 9) < 3);
         2: rsp_stall <= (hold_cnt > 1) || ($urandom_range(0, 9) < 8);
         default: rsp_stall <= (hold_cnt > 1) || cycles[2];
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pend_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stream encoder
   bit [63:0] acc;
   int acc_n, enc_w, enc_max;
   bit enc16;
   logic [7:0] data_q[$];

   task automatic put_code(input bit [31:0] val, input int w);
      acc |= ({32'd0, val} & ((64'd1 << w) - 1)) << acc_n;
      acc_n += w;
      while (acc_n >= 8) begin
         data_q.push_back(acc[7:0]);
         acc >>= 8;
         acc_n -= 8;
      end
   endtask

   function automatic bit [31:0] border_of(input int w);
      return enc16 ? (32'hFFFF >> (17 - w)) - 8 : ((32'hFF >> (9 - w)) - 4) & 32'hFF;
   endfunction

   function automatic bit is_ctl(input bit [31:0] val);
      bit [31:0] bd;
      bd = border_of(enc_w);
      if (enc_w < 7) return val == (32'd1 << (enc_w - 1));
      if (enc_w < enc_max) return val > bd && val <= bd + (enc16 ? 16 : 8);
      return val[enc_max - 1];
   endfunction

   task automatic set_width(input int nw);
      if (nw != enc_w) begin
         if (enc_w < 7) begin
            put_code(32'd1 << (enc_w - 1), enc_w);
            put_code(nw < enc_w ? nw - 1 : nw - 2, enc16 ? 4 : 3);
         end else if (enc_w < enc_max) begin
            put_code(border_of(enc_w) + (nw < enc_w ? nw : nw - 1), enc_w);
         end else begin
            put_code((32'd1 << (enc_max - 1)) | (nw - 1), enc_w);
         end
         enc_w = nw;
      end
   endtask

   task automatic gen_block(input int nsamp, input int pchg, input bit narrow,
                            input bit bad);
      bit [31:0] val;
      int bad_at;
      data_q.delete();
      acc = 0;
      acc_n = 0;
      enc_max = enc16 ? 17 : 9;
      enc_w = enc_max;
      if (narrow) set_width(1);
      bad_at = bad ? $urandom_range(0, nsamp - 1) : -1;
      for (int i = 0; i < nsamp; i++) begin
         if (i == bad_at) begin
            set_width(enc_max);
            // top bit code giving width zero or one too wide
            put_code((32'd1 << (enc_max - 1)) | ($urandom_range(0, 1) ? 32'hFF : enc_max),
                     enc_max);
            break;
         end
         if ($urandom_range(0, 99) < pchg) set_width($urandom_range(1, enc_max));
         do begin
            case ($urandom_range(0, 7))
               0: val = 0;
               1: val = 32'hFFFFFFFF;
               default: val = $urandom;
            endcase
            val &= (32'd1 << enc_w) - 1;
         end while (is_ctl(val));
         put_code(val, enc_w);
      end
      if (acc_n > 0) put_code(0, 8 - acc_n);
      stream_q.push_back(data_q.size() & 8'hFF);
      stream_q.push_back((data_q.size() >> 8) & 8'hFF);
      foreach (data_q[i]) stream_q.push_back(data_q[i]);
   endtask

   task automatic run_stream(input bit wide, input bit dbl, input logic [3:0] stride,
                             input int count, input int pchg, input bit narrow,
                             input bit bad, input bit overrun, input int trail,
                             input bit hold);
      int rem, ns, cap, blk;
      logic [31:0] avail;
      stream_q.delete();
      enc16 = wide;
      cap = wide ? 32'h4000 : 32'h8000;
      rem = count;
      blk = 0;
      while (rem > 0) begin
         ns = rem < cap ? rem : cap;
         rem -= ns;
         gen_block(ns, pchg, narrow && blk == 0, bad && rem == 0);
         blk++;
      end
      if (count == 0) stream_q.push_back($urandom_range(0, 255));
      avail = overrun ? stream_q.size() - 1
            : ($urandom_range(0, 3) == 0 ? 32'hFFFFFFFF : stream_q.size());
      repeat (trail) stream_q.push_back($urandom_range(0, 255));
      csr_write(it_sdd_pkg::REG_SIXTEEN_BIT, {31'd0, wide});
      csr_write(it_sdd_pkg::REG_DOUBLE_INTEGRATE, {31'd0, dbl});
      csr_write(it_sdd_pkg::REG_CHANNEL_STRIDE, {28'd0, stride});
      csr_write(it_sdd_pkg::REG_INPUT_LENGTH, avail);
      csr_write(it_sdd_pkg::REG_SAMPLE_COUNT, count);
      if (hold) hold_kick++;
      foreach (stream_q[i]) pend_q.push_back(stream_q[i]);
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // nothing to decode straight out of reset, then an ignored byte
      pend_q.push_back(8'hFF);
      pend_q.push_back(8'h00);
      wait_idle();
      run_stream(0, 0, 4'd1, 5, 30, 0, 0, 0, 0, 0);
      run_stream(1, 1, 4'd0, 6, 30, 0, 0, 0, 1, 0);
      run_stream(0, 1, 4'd15, 8, 100, 1, 0, 0, 0, 0);
      run_stream(0, 0, 4'd8, 10, 20, 0, 1, 0, 2, 0);
      run_stream(1, 0, 4'd3, 7, 20, 0, 1, 0, 0, 0);
      run_stream(1, 1, 4'd1, 4, 10, 0, 0, 1, 1, 0);
      // huge count, block cannot fit into an empty input
      csr_write(it_sdd_pkg::REG_INPUT_LENGTH, 32'd0);
      csr_write(it_sdd_pkg::REG_SAMPLE_COUNT, 32'hFFFFFFFF);
      pend_q.push_back(8'hFF);
      pend_q.push_back(8'hFF);
      pend_q.push_back(8'h5A);
      wait_idle();

      // run at width one, with a long output hold-off
      run_stream(1, 0, 4'd2, 120, 0, 1, 0, 0, 0, 1);

      while (items_sent < 250) begin
         if ($urandom_range(0, 9) == 0) begin
            csr_write(it_sdd_pkg::REG_SIXTEEN_BIT, $urandom_range(0, 1));
            csr_write(it_sdd_pkg::REG_INPUT_LENGTH, $urandom);
            csr_write(it_sdd_pkg::REG_SAMPLE_COUNT, $urandom_range(0, 40));
            repeat ($urandom_range(1, 12)) pend_q.push_back($urandom_range(0, 255));
            wait_idle();
         end else begin
            run_stream($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15),
                       $urandom_range(1, 30), $urandom_range(0, 40),
                       $urandom_range(0, 5) == 0, $urandom_range(0, 6) == 0,
                       $urandom_range(0, 9) == 0, $urandom_range(0, 2), 0);
         end
      end
      wait_idle();

      $display("covered %0d input bytes, %0d samples and %0d status results",
               items_sent, samples_seen, status_seen);
      $display("both sample widths, both integrator outputs, width changes and stream errors");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_q.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: it_sample_delta_decompress.f
rtl/core/it_sdd_pkg.sv
rtl/core/it_sdd_ctrl.sv
rtl/core/it_sdd_dpath.sv
rtl/core/it_sdd_outq.sv
rtl/core/it_sample_delta_decompress.sv
tb/it_sample_delta_decompress_tb.sv
